FILE: rtl/cdq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package cdq_pkg;

  typedef enum logic [1:0] {
    CMD_PUSH_FRONT = 2'd0,
    CMD_PUSH_REAR  = 2'd1,
    CMD_POP_FRONT  = 2'd2,
    CMD_POP_REAR   = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    STS_DONE  = 2'd0,
    STS_FULL  = 2'd1,
    STS_EMPTY = 2'd2
  } status_t;

  typedef enum logic {
    ST_IDLE  = 1'b0,
    ST_FETCH = 1'b1
  } state_t;

  localparam int unsigned WORD_W = 32;
  localparam int unsigned OCC_W  = 4;

  // value reported at both ends when nothing is held
  localparam logic signed [WORD_W-1:0] EMPTY_WORD = '1;

  typedef struct packed {
    cmd_t                     command;
    logic signed [WORD_W-1:0] value;
  } in_t;

  typedef struct packed {
    status_t                  status;
    logic signed [WORD_W-1:0] front_value;
    logic signed [WORD_W-1:0] rear_value;
    logic [OCC_W-1:0]         occupancy;
    logic                     is_empty;
    logic                     is_full;
  } out_t;

endpackage

`default_nettype wire

FILE: rtl/circular_deque_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// result: a push, a rejected item or a pop of the last entry is registered straight into the output
//   register; a pop that leaves entries behind passes the slot memory read register first
// throughput: 1 item per cycle for pushes and rejects while the output is not stalled; such pops
//   stall the input while the new end word is read from the slot memory
// reset: pointers, count, state and output valid clear; the slot memory is not cleared
//   and its read data is used only from slots that hold an entry
module circular_deque_unit
  import cdq_pkg::*;
#(
  parameter int unsigned DEPTH = 8
) (
  input  wire       clk,
  input  wire       rst_n,
  input  wire       in_valid,
  output logic      in_stall,
  input  wire in_t  in_data,
  output logic      out_valid,
  input  wire       out_stall,
  output out_t      out_data
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST_IDX  = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT  = CW'(DEPTH);

  // slot memory, one write port and one registered read port
  logic signed [WORD_W-1:0] mem [DEPTH];
  logic signed [WORD_W-1:0] rd_data_r;
  logic [AW-1:0]            rd_addr;
  logic                     wr_en;
  logic [AW-1:0]            wr_addr;

  // control state
  state_t          state_r, state_nxt;
  logic [AW-1:0]   head_r, head_nxt;
  logic [AW-1:0]   tail_r, tail_nxt;
  logic [CW-1:0]   count_r, count_nxt;

  // cached end words, so that pushes need no memory read
  logic signed [WORD_W-1:0] front_r, front_nxt;
  logic signed [WORD_W-1:0] rear_r, rear_nxt;
  logic                     fetch_front_r, fetch_front_nxt;

  // output register
  logic out_valid_r, out_valid_nxt;
  out_t out_data_r, out_data_nxt;

  // handshake and sequencing
  logic    accept;
  logic    load_out;
  logic    need_fetch;
  logic    is_push;
  logic    is_empty_now;
  logic    is_full_now;
  status_t status_cur;

  function automatic logic [AW-1:0] step_up(input logic [AW-1:0] idx);
    step_up = (idx == LAST_IDX) ? '0 : idx + AW'(1);
  endfunction

  function automatic logic [AW-1:0] step_down(input logic [AW-1:0] idx);
    step_down = (idx == '0) ? LAST_IDX : idx - AW'(1);
  endfunction

  assign is_push      = (in_data.command == CMD_PUSH_FRONT) ||
                        (in_data.command == CMD_PUSH_REAR);
  assign is_empty_now = (count_r == '0);
  assign is_full_now  = (count_r == FULL_CNT);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept && need_fetch) begin
          state_nxt = ST_FETCH;
        end
      end
      ST_FETCH: begin
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // fsm outputs: stall while a read is pending or the result is held up
  always_comb begin
    in_stall = 1'b1;
    load_out = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_stall = out_valid_r && out_stall;
        load_out = in_valid && !(out_valid_r && out_stall) && !need_fetch;
      end
      ST_FETCH: begin
        in_stall = 1'b1;
        load_out = 1'b1;
      end
      default: begin
        in_stall = 1'b1;
        load_out = 1'b0;
      end
    endcase
  end

  assign accept = (state_r == ST_IDLE) && in_valid && !in_stall;

  // datapath: pointer moves, slot write, read address, result
  always_comb begin
    head_nxt        = head_r;
    tail_nxt        = tail_r;
    count_nxt       = count_r;
    front_nxt       = front_r;
    rear_nxt        = rear_r;
    fetch_front_nxt = fetch_front_r;
    wr_en           = 1'b0;
    wr_addr         = head_r;
    rd_addr         = head_r;
    need_fetch      = 1'b0;
    status_cur      = STS_DONE;

    if (state_r == ST_FETCH) begin
      // the new end word arrives from memory
      if (fetch_front_r) begin
        front_nxt = rd_data_r;
      end else begin
        rear_nxt = rd_data_r;
      end
    end else if (is_push && is_full_now) begin
      status_cur = STS_FULL;
    end else if (!is_push && is_empty_now) begin
      status_cur = STS_EMPTY;
    end else begin
      case (in_data.command)
        CMD_PUSH_FRONT: begin
          head_nxt  = is_empty_now ? LAST_IDX : step_down(head_r);
          tail_nxt  = is_empty_now ? LAST_IDX : tail_r;
          front_nxt = in_data.value;
          rear_nxt  = is_empty_now ? in_data.value : rear_r;
          wr_en     = accept;
          wr_addr   = head_nxt;
          count_nxt = count_r + CW'(1);
        end
        CMD_PUSH_REAR: begin
          head_nxt  = is_empty_now ? '0 : head_r;
          tail_nxt  = is_empty_now ? '0 : step_up(tail_r);
          rear_nxt  = in_data.value;
          front_nxt = is_empty_now ? in_data.value : front_r;
          wr_en     = accept;
          wr_addr   = tail_nxt;
          count_nxt = count_r + CW'(1);
        end
        CMD_POP_FRONT: begin
          count_nxt       = count_r - CW'(1);
          fetch_front_nxt = 1'b1;
          if (count_nxt == '0) begin
            head_nxt = '0;
            tail_nxt = '0;
          end else begin
            head_nxt   = step_up(head_r);
            rd_addr    = head_nxt;
            need_fetch = 1'b1;
          end
        end
        CMD_POP_REAR: begin
          count_nxt       = count_r - CW'(1);
          fetch_front_nxt = 1'b0;
          if (count_nxt == '0) begin
            head_nxt = '0;
            tail_nxt = '0;
          end else begin
            tail_nxt   = step_down(tail_r);
            rd_addr    = tail_nxt;
            need_fetch = 1'b1;
          end
        end
        default: begin
          status_cur = STS_DONE;
        end
      endcase
    end

    out_data_nxt.status      = status_cur;
    out_data_nxt.occupancy   = OCC_W'(count_nxt);
    out_data_nxt.is_empty    = (count_nxt == '0);
    out_data_nxt.is_full     = (count_nxt == FULL_CNT);
    out_data_nxt.front_value = (count_nxt == '0) ? EMPTY_WORD : front_nxt;
    out_data_nxt.rear_value  = (count_nxt == '0) ? EMPTY_WORD : rear_nxt;
  end

  // output valid: set on load, cleared once the transfer completes
  always_comb begin
    if (load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  // slot memory
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= in_data.value;
    end
    rd_data_r <= mem[rd_addr];
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      head_r      <= '0;
      tail_r      <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (accept || state_r == ST_FETCH) begin
        head_r  <= head_nxt;
        tail_r  <= tail_nxt;
        count_r <= count_nxt;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept || state_r == ST_FETCH) begin
      front_r       <= front_nxt;
      rear_r        <= rear_nxt;
      fetch_front_r <= fetch_front_nxt;
    end
    if (load_out) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTH
  // occupancy never passes the slot count
  assert property (@(posedge clk) disable iff (!rst_n) count_r <= FULL_CNT)
    else $error("deque count beyond depth");

  // a memory read completes only into a free output register
  assert property (@(posedge clk) disable iff (!rst_n)
                   (state_r == ST_FETCH) |-> !out_valid_r)
    else $error("fetch with output register occupied");

  // the read wait state always gives way to idle at the next clock
  assert property (@(posedge clk) disable iff (!rst_n)
                   (state_r == ST_FETCH) |=> (state_r == ST_IDLE))
    else $error("fetch state held too long");

  // an empty deque keeps both pointers at slot zero
  assert property (@(posedge clk) disable iff (!rst_n)
                   (count_r == '0) |-> (head_r == '0 && tail_r == '0))
    else $error("empty deque with moved pointers");

  // every accepted item leads to a loaded result, either at once or from the fetch state
  assert property (@(posedge clk) disable iff (!rst_n) accept |-> ##[0:1] load_out)
    else $error("accepted item without result");
`endif

endmodule

`default_nettype wire
